// ===== design/ipv4cs_pkg.sv =====
// shared types and constants of the ipv4/tcp checksum stream block
package ipv4cs_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_IHL = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    // header byte positions
    localparam logic [15:0] POS_IHL      = 16'd0;
    localparam logic [15:0] POS_LEN_HI   = 16'd2;
    localparam logic [15:0] POS_LEN_LO   = 16'd3;
    localparam logic [15:0] POS_CSUM_HI  = 16'd10;
    localparam logic [15:0] POS_CSUM_LO  = 16'd11;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_DST_FIRST = 16'd16;
    localparam logic [15:0] POS_DST_LAST  = 16'd19;
    localparam logic [15:0] POS_MAX      = 16'hffff;

    // offset of the checksum field inside the tcp header
    localparam logic [15:0] TCP_CSUM_OFFSET = 16'd16;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [15:0] MIN_BYTES       = 16'd4;
    localparam logic [31:0] PROTO_TCP       = 32'h0000_0006;

    // everything the finishing stages need for one packet
    typedef struct packed {
        logic [31:0] header_sum;
        logic [31:0] segment_sum;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] tcp_length;
        logic [1:0]  status;
    } finish_t;

endpackage

// ===== design/ipv4cs_accum.sv =====
// per-byte header capture and word accumulation, one beat per cycle while s_tready is high
module ipv4cs_accum (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 fin_valid,
    output ipv4cs_pkg::finish_t  fin,
    input  logic                 fin_ready
);

    logic [15:0] pos_reg;
    logic [3:0]  ihl_reg;
    logic [15:0] tot_len_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [31:0] hdr_sum_reg;
    logic [31:0] seg_sum_reg;
    logic        fin_valid_reg;
    ipv4cs_pkg::finish_t fin_reg;

    logic [3:0]  ihl_next;
    logic [15:0] tot_len_next;
    logic [31:0] src_next;
    logic [31:0] dst_next;
    logic [31:0] hdr_sum_next;
    logic [31:0] seg_sum_next;
    logic [15:0] pos_next;
    logic [15:0] hlen;
    logic [15:0] word;
    logic        hdr_add;
    logic        seg_add;
    logic [1:0]  status;
    logic        accept;

    assign s_tready  = !fin_valid_reg || fin_ready;
    assign accept    = s_tvalid && s_tready;
    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    // field capture, using the current byte where it lands
    always_comb begin
        ihl_next     = ihl_reg;
        tot_len_next = tot_len_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        if (pos_reg == ipv4cs_pkg::POS_IHL) begin
            ihl_next = s_tdata[3:0];
        end else if (pos_reg == ipv4cs_pkg::POS_LEN_HI) begin
            tot_len_next = {s_tdata, tot_len_reg[7:0]};
        end else if (pos_reg == ipv4cs_pkg::POS_LEN_LO) begin
            tot_len_next = {tot_len_reg[15:8], s_tdata};
        end else if (pos_reg inside {[ipv4cs_pkg::POS_SRC_FIRST:ipv4cs_pkg::POS_SRC_LAST]}) begin
            src_next = {src_reg[23:0], s_tdata};
        end else if (pos_reg inside {[ipv4cs_pkg::POS_DST_FIRST:ipv4cs_pkg::POS_DST_LAST]}) begin
            dst_next = {dst_reg[23:0], s_tdata};
        end
    end

    // byte lane and region tests
    always_comb begin
        hlen = {10'd0, ihl_next, 2'b00};
        word = pos_reg[0] ? {8'd0, s_tdata} : {s_tdata, 8'd0};
        hdr_add = (pos_reg < hlen) && (pos_reg != ipv4cs_pkg::POS_CSUM_HI)
                  && (pos_reg != ipv4cs_pkg::POS_CSUM_LO);
        seg_add = (pos_reg >= hlen) && (pos_reg < tot_len_next)
                  && (pos_reg != hlen + ipv4cs_pkg::TCP_CSUM_OFFSET)
                  && (pos_reg != hlen + ipv4cs_pkg::TCP_CSUM_OFFSET + 16'd1);
        hdr_sum_next = hdr_add ? hdr_sum_reg + {16'd0, word} : hdr_sum_reg;
        seg_sum_next = seg_add ? seg_sum_reg + {16'd0, word} : seg_sum_reg;
        pos_next = (pos_reg == ipv4cs_pkg::POS_MAX) ? pos_reg : pos_reg + 16'd1;
    end

    // status from the byte count including this beat
    always_comb begin
        if (pos_next < ipv4cs_pkg::MIN_BYTES) begin
            status = ipv4cs_pkg::STATUS_SHORT;
        end else if ((ihl_next < ipv4cs_pkg::IHL_MIN) || (hlen > tot_len_next)) begin
            status = ipv4cs_pkg::STATUS_BAD_IHL;
        end else if (pos_next < tot_len_next) begin
            status = ipv4cs_pkg::STATUS_SHORT;
        end else begin
            status = ipv4cs_pkg::STATUS_OK;
        end
    end

    // packet state, cleared after each last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            ihl_reg     <= '0;
            tot_len_reg <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            hdr_sum_reg <= '0;
            seg_sum_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                pos_reg     <= '0;
                ihl_reg     <= '0;
                tot_len_reg <= '0;
                src_reg     <= '0;
                dst_reg     <= '0;
                hdr_sum_reg <= '0;
                seg_sum_reg <= '0;
            end else begin
                pos_reg     <= pos_next;
                ihl_reg     <= ihl_next;
                tot_len_reg <= tot_len_next;
                src_reg     <= src_next;
                dst_reg     <= dst_next;
                hdr_sum_reg <= hdr_sum_next;
                seg_sum_reg <= seg_sum_next;
            end
        end
    end

    // hand-off register toward the finishing stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (accept && s_tlast) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_ready) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            fin_reg.header_sum  <= hdr_sum_next;
            fin_reg.segment_sum <= seg_sum_next;
            fin_reg.src_addr    <= src_next;
            fin_reg.dst_addr    <= dst_next;
            fin_reg.tcp_length  <= tot_len_next - hlen;
            fin_reg.status      <= status;
        end
    end

endmodule

// ===== design/ipv4cs_finish.sv =====
// pseudo-header add, carry fold and complement, with the output register
module ipv4cs_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fin_valid,
    input  ipv4cs_pkg::finish_t  fin,
    output logic                 fin_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    logic        sum_valid_reg;
    logic [31:0] tcp_sum_reg;
    logic [31:0] hdr_sum_reg;
    logic [1:0]  sum_status_reg;
    logic        out_valid_reg;
    logic [15:0] ip_csum_reg;
    logic [15:0] tcp_csum_reg;
    logic [1:0]  out_status_reg;

    logic        out_ready;
    logic        sum_ready;
    logic [31:0] tcp_sum_next;
    logic [16:0] tcp_fold1;
    logic [16:0] tcp_fold2;
    logic [16:0] hdr_fold1;
    logic [16:0] hdr_fold2;
    logic        status_ok;

    assign out_ready = !out_valid_reg || m_tready;
    assign sum_ready = !sum_valid_reg || out_ready;
    assign fin_ready = sum_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {tcp_csum_reg, ip_csum_reg};
    assign m_tuser   = out_status_reg;

    // pseudo-header: address halves, protocol and segment length
    always_comb begin
        tcp_sum_next = fin.segment_sum
                       + {16'd0, fin.src_addr[31:16]} + {16'd0, fin.src_addr[15:0]}
                       + {16'd0, fin.dst_addr[31:16]} + {16'd0, fin.dst_addr[15:0]}
                       + ipv4cs_pkg::PROTO_TCP + {16'd0, fin.tcp_length};
    end

    // two carry folds for each sum
    always_comb begin
        tcp_fold1 = {1'b0, tcp_sum_reg[15:0]} + {1'b0, tcp_sum_reg[31:16]};
        tcp_fold2 = {1'b0, tcp_fold1[15:0]} + {16'd0, tcp_fold1[16]};
        hdr_fold1 = {1'b0, hdr_sum_reg[15:0]} + {1'b0, hdr_sum_reg[31:16]};
        hdr_fold2 = {1'b0, hdr_fold1[15:0]} + {16'd0, hdr_fold1[16]};
        status_ok = (sum_status_reg == ipv4cs_pkg::STATUS_OK);
    end

    // sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            sum_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && fin_valid) begin
            tcp_sum_reg    <= tcp_sum_next;
            hdr_sum_reg    <= fin.header_sum;
            sum_status_reg <= fin.status;
        end
    end

    // output register, checksums forced to zero on an error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && sum_valid_reg) begin
            ip_csum_reg    <= status_ok ? ~hdr_fold2[15:0] : 16'd0;
            tcp_csum_reg   <= status_ok ? ~tcp_fold2[15:0] : 16'd0;
            out_status_reg <= sum_status_reg;
        end
    end

endmodule

// ===== design/ipv4_tcp_checksum_stream_top.sv =====
// top level of the ipv4/tcp checksum stream block
//
// An IPv4 packet carrying TCP enters on the s_ stream one byte per beat,
// starting at the first byte of the IPv4 header; s_tlast marks its final
// byte. For every packet one result beat leaves on the m_ stream with the
// IPv4 header checksum, the TCP checksum over segment and pseudo-header,
// and a status code (ok, bad header length, packet short). On an error
// both checksums read as zero.
//
// Throughput: one byte per clock while s_tready is high, set by the single
// add into each running word sum. After the last byte the result passes
// the hand-off register, the sum register (pseudo-header add) and the
// output register (fold and complement). Back-to-back packets are fine;
// the next packet's first byte may follow the last byte directly.
//
// Reset (aresetn low, synchronous) clears the byte counter, captured
// header fields, both sums and every valid flag. When the receiver holds
// m_tready low the result waits in the output register; two further
// finished packets can queue in the pipeline before s_tready drops.
module ipv4_tcp_checksum_stream_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // packet_byte
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [31:0] m_tdata,   // ip_checksum [15:0], tcp_checksum [31:16]
    output logic [1:0]  m_tuser,   // status
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic                fin_valid;
    logic                fin_ready;
    ipv4cs_pkg::finish_t fin;

    // byte capture and accumulation
    ipv4cs_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready)
    );

    // pseudo-header, fold and output register
    ipv4cs_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/ipv4cs_checker.sv =====
// port-level checks on the ipv4/tcp checksum stream block, bound to the top level
module ipv4cs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    logic [2:0] pending_reg;
    logic       last_in;
    logic       result_out;

    assign last_in    = s_tvalid && s_tready && s_tlast;
    assign result_out = m_tvalid && m_tready;

    // packets whose result has not yet been taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + {2'd0, last_in} - {2'd0, result_out};
        end
    end

    // no result beat after a reset cycle
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // error results carry zero checksums
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ipv4cs_pkg::STATUS_OK) |-> m_tdata == 32'd0)
        else $error("checksum nonzero on error status");

    // every result belongs to a packet, and at most three are in flight
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg <= 3'd3) && (!m_tvalid || pending_reg != 3'd0))
        else $error("result count out of step with packets");

    // an empty output side never stalls the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with nothing waiting");

endmodule

bind ipv4_tcp_checksum_stream_top ipv4cs_checker u_checker (.*);
